// File: src/amd_pkg.sv
package amd_pkg;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int CAL_W      = 12;
   localparam int HOLD_W     = 16;
   localparam int TIME_W     = 32;
   localparam int VALUE_W    = 22;
   localparam int BAR_W      = 4;
   localparam int MODE_W     = 2;
   localparam int SUM_W      = 26;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // serial divider operands
   localparam int DVD_W = 21;
   localparam int DVS_W = 12;

   localparam int FILTER_SHIFT_DEF = 14;

   localparam logic [CAL_W-1:0]  TEMP_CAL_LOW_RST  = 12'd1750;
   localparam logic [CAL_W-1:0]  TEMP_CAL_HIGH_RST = 12'd1300;
   localparam logic [CAL_W-1:0]  VREF_CAL_RST      = 12'd1520;
   localparam logic [HOLD_W-1:0] HOLD_MS_RST       = 16'd1000;

   typedef enum logic [MODE_W-1:0] {
      MODE_POT  = 2'd0,
      MODE_VOLT = 2'd1,
      MODE_TEMP = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_CAL_LOW  = 2'd0,
      CSR_TEMP_CAL_HIGH = 2'd1,
      CSR_VREF_CAL      = 2'd2,
      CSR_HOLD_MS       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: src/amd_if.sv
interface amd_req_if import amd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SAMPLE_W-1:0] sample;
   logic                end_of_sequence;
   logic                s1_pressed;
   logic                s2_pressed;
   logic [TIME_W-1:0]   now_ms;

   modport source (
      output valid, cmd, sample, end_of_sequence, s1_pressed, s2_pressed, now_ms,
      input  ready
   );
   modport sink (
      input  valid, cmd, sample, end_of_sequence, s1_pressed, s2_pressed, now_ms,
      output ready
   );
endinterface

interface amd_rsp_if import amd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] display_value;
   logic [BAR_W-1:0]   bar_level;
   logic [MODE_W-1:0]  shown_mode;
   logic               div_fault;

   modport source (
      output valid, display_value, bar_level, shown_mode, div_fault,
      input  ready
   );
   modport sink (
      input  valid, display_value, bar_level, shown_mode, div_fault,
      output ready
   );
endinterface

// File: src/amd_divider.sv
module amd_divider import amd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVD_W-1:0] quo_in;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             q_bit;

   // restoring step: one quotient bit per cycle, dividend shifts out at the top
   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      q_bit  = (trial >= {1'b0, dvs_ff});
      rem_in = q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_in = {quo_ff[DVD_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: src/adc_monitor_with_mode_display_core.sv
// ADC monitor with a three-mode numeric display and a bar graph.
// req_chan carries two kinds of transaction: a conversion result (cmd 0),
// routed by a sequence counter to the pot filter, temperature or reference
// store, and a display poll (cmd 1), which yields one rsp_chan transaction
// with the current mode's value, the bar level, the mode shown and a fault
// flag for a zero divisor. The buttons and the hold timer then update the mode.
// The csr_ port writes the calibration and hold registers, one per cycle.
// A conversion is stored at acceptance. A poll in pot mode, or one that hits a
// zero divisor, goes straight to the done state; a voltage or temperature poll
// first runs the bit-serial divider, which resolves one of its 21 quotient bits
// per cycle. From the done state the result is loaded into the output register
// once that register is free, and the input is freed then.
// req_chan.ready is high whenever no poll is in progress. The result sits in
// an output register; a further poll may be accepted while it waits, and its
// own result is held back until rsp_chan has taken the earlier one.
// Reset (synchronous) restores the calibration defaults, clears filter,
// samples, counter and hold timer, selects pot mode and empties the output.
module adc_monitor_with_mode_display_core import amd_pkg::*; #(
   parameter int FILTER_SHIFT = FILTER_SHIFT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   amd_req_if.sink               req_chan,
   amd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [CAL_W-1:0]  temp_cal_low_ff;
   logic [CAL_W-1:0]  temp_cal_high_ff;
   logic [CAL_W-1:0]  vref_cal_ff;
   logic [HOLD_W-1:0] hold_ms_ff;

   // block state
   logic [1:0]          seq_channel_ff;
   logic [SUM_W-1:0]    filter_sum_ff;
   logic [SAMPLE_W-1:0] pot_level_ff;
   logic [SAMPLE_W-1:0] temp_sample_ff;
   logic [SAMPLE_W-1:0] vref_sample_ff;
   mode_type            view_mode_ff;
   logic [TIME_W-1:0]   hold_start_ff;

   // poll in progress
   mode_type shown_ff;
   logic     fault_ff;
   logic     neg_ff;

   // result register
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [BAR_W-1:0]   rsp_bar_ff;
   logic [MODE_W-1:0]  rsp_mode_ff;
   logic               rsp_fault_ff;

   logic        req_acc;
   logic        conv_acc;
   logic        poll_acc;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // filter
   logic [SUM_W-1:0]    sum_shifted;
   logic [SAMPLE_W-1:0] level_in;
   logic [SUM_W-1:0]    filter_sum_in;

   // operands
   mode_type          shown_in;
   logic signed [12:0] t_diff;
   logic signed [19:0] t_num;
   logic [19:0]        t_num_abs;
   logic signed [12:0] t_den;
   logic [DVS_W-1:0]   t_den_abs;
   logic               zero_div;

   // hold timer
   logic [TIME_W-1:0] hold_base;
   logic [TIME_W-1:0] hold_limit;
   mode_type          view_mode_in;

   // result forming
   logic [VALUE_W-1:0] q_mag;
   logic [VALUE_W-1:0] value_in;
   logic [20:0]        pot_x500;
   logic [15:0]        pot_x9;
   logic               out_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign conv_acc = req_acc && !req_chan.cmd;
   assign poll_acc = req_acc && req_chan.cmd;

   always_comb begin
      sum_shifted   = filter_sum_ff >> FILTER_SHIFT;
      level_in      = (|sum_shifted[SUM_W-1:SAMPLE_W]) ? {SAMPLE_W{1'b1}}
                                                       : sum_shifted[SAMPLE_W-1:0];
      filter_sum_in = filter_sum_ff - SUM_W'(level_in) + SUM_W'(req_chan.sample);
   end

   always_comb begin
      unique case (view_mode_ff)
         MODE_VOLT: shown_in = MODE_VOLT;
         MODE_TEMP: shown_in = MODE_TEMP;
         default:   shown_in = MODE_POT;
      endcase

      t_diff    = $signed({1'b0, temp_sample_ff}) - $signed({1'b0, temp_cal_low_ff});
      t_num     = 20'(t_diff) * 20'sd80;
      t_num_abs = t_num[19] ? 20'(-t_num) : 20'(t_num);
      t_den     = $signed({1'b0, temp_cal_high_ff}) - $signed({1'b0, temp_cal_low_ff});
      t_den_abs = t_den[12] ? DVS_W'(-t_den) : DVS_W'(t_den);

      div_req.start = 1'b0;
      if (shown_in == MODE_TEMP) begin
         div_req.dividend = {1'b0, t_num_abs};
         div_req.divisor  = t_den_abs;
         zero_div         = (t_den == 13'sd0);
      end else begin
         div_req.dividend = DVD_W'(vref_cal_ff) * DVD_W'(330);
         div_req.divisor  = vref_sample_ff;
         zero_div         = (vref_sample_ff == '0);
      end
      if (poll_acc && (shown_in != MODE_POT) && !zero_div) begin
         div_req.start = 1'b1;
      end
   end

   amd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // S2 beats S1; either restarts the hold timer before the expiry check
   always_comb begin
      hold_base  = (req_chan.s1_pressed || req_chan.s2_pressed) ? req_chan.now_ms
                                                                : hold_start_ff;
      hold_limit = hold_base + TIME_W'(hold_ms_ff);
      priority if (req_chan.now_ms > hold_limit) begin
         view_mode_in = MODE_POT;
      end else if (req_chan.s2_pressed) begin
         view_mode_in = MODE_TEMP;
      end else if (req_chan.s1_pressed) begin
         view_mode_in = MODE_VOLT;
      end else begin
         view_mode_in = view_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_low_ff  <= TEMP_CAL_LOW_RST;
         temp_cal_high_ff <= TEMP_CAL_HIGH_RST;
         vref_cal_ff      <= VREF_CAL_RST;
         hold_ms_ff       <= HOLD_MS_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_CAL_LOW:  temp_cal_low_ff  <= csr_wdata[CAL_W-1:0];
            CSR_TEMP_CAL_HIGH: temp_cal_high_ff <= csr_wdata[CAL_W-1:0];
            CSR_VREF_CAL:      vref_cal_ff      <= csr_wdata[CAL_W-1:0];
            CSR_HOLD_MS:       hold_ms_ff       <= csr_wdata[HOLD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_channel_ff <= '0;
         filter_sum_ff  <= '0;
         pot_level_ff   <= '0;
         temp_sample_ff <= '0;
         vref_sample_ff <= '0;
         view_mode_ff   <= MODE_POT;
         hold_start_ff  <= '0;
      end else begin
         if (conv_acc) begin
            unique case (seq_channel_ff)
               2'd0: begin
                  pot_level_ff  <= level_in;
                  filter_sum_ff <= filter_sum_in;
               end
               2'd1: temp_sample_ff <= req_chan.sample;
               2'd2: vref_sample_ff <= req_chan.sample;
               default: ;
            endcase
            if (req_chan.end_of_sequence) begin
               seq_channel_ff <= '0;
            end else if (seq_channel_ff != 2'd3) begin
               seq_channel_ff <= seq_channel_ff + 2'd1;
            end
         end
         if (poll_acc) begin
            view_mode_ff  <= view_mode_in;
            hold_start_ff <= hold_base;
         end
      end
   end

   always_comb begin
      q_mag    = {1'b0, div_rsp.quotient};
      pot_x500 = 21'(pot_level_ff) * 21'd500;
      pot_x9   = 16'(pot_level_ff) * 16'd9;
      if (fault_ff) begin
         value_in = '0;
      end else begin
         unique case (shown_ff)
            MODE_TEMP: value_in = (neg_ff ? -q_mag : q_mag) + VALUE_W'(30);
            MODE_VOLT: value_in = q_mag;
            default:   value_in = VALUE_W'(pot_x500[20:12]);
         endcase
      end
      out_free = !rsp_valid_ff || rsp_chan.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (poll_acc) begin
                  shown_ff <= shown_in;
                  fault_ff <= (shown_in != MODE_POT) && zero_div;
                  neg_ff   <= t_num[19] ^ t_den[12];
                  state_ff <= div_req.start ? ST_DIV : ST_DONE;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_value_ff <= value_in;
                  rsp_bar_ff   <= pot_x9[15:12];
                  rsp_mode_ff  <= shown_ff;
                  rsp_fault_ff <= fault_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.display_value = rsp_value_ff;
   assign rsp_chan.bar_level     = rsp_bar_ff;
   assign rsp_chan.shown_mode    = rsp_mode_ff;
   assign rsp_chan.div_fault     = rsp_fault_ff;

endmodule

// File: src/amd_checker.sv
module amd_checker import amd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] display_value,
   input logic [BAR_W-1:0]   bar_level,
   input logic [MODE_W-1:0]  shown_mode,
   input logic               div_fault
);

   // a stalled result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(display_value)
         && $stable(bar_level) && $stable(shown_mode) && $stable(div_fault))
      else $error("result changed while stalled");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && div_fault |-> display_value == '0)
      else $error("faulted result with non-zero value");

   a_pot_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && shown_mode == MODE_POT |-> !div_fault && display_value < VALUE_W'(500))
      else $error("pot mode result out of range or faulted");

   a_mode_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> shown_mode != 2'd3 && bar_level <= BAR_W'(8))
      else $error("bad mode code or bar level");

endmodule

bind adc_monitor_with_mode_display_core amd_checker u_amd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .display_value (rsp_chan.display_value),
   .bar_level     (rsp_chan.bar_level),
   .shown_mode    (rsp_chan.shown_mode),
   .div_fault     (rsp_chan.div_fault)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import amd_pkg::*;

   localparam bit CMD_CONV = 1'b0;
   localparam bit CMD_POLL = 1'b1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 292;
   localparam int NUM_PHASES = 6;

   typedef struct {
      bit                cmd;
      bit [SAMPLE_W-1:0] sample;
      bit                eos;
      bit                s1;
      bit                s2;
      bit [TIME_W-1:0]   now;
   } monitor_req_type;

   typedef struct {
      bit [VALUE_W-1:0] value;
      bit [BAR_W-1:0]   bar;
      bit [MODE_W-1:0]  mode;
      bit               fault;
   } display_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   amd_req_if req_chan ();
   amd_rsp_if rsp_chan ();

   adc_monitor_with_mode_display_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [CAL_W-1:0]    cal_lo, cal_hi, vref_cal_r;
   logic [HOLD_W-1:0]   hold_r;
   logic [1:0]          chan_ctr;
   logic [SUM_W-1:0]    flt_sum;
   logic [SAMPLE_W-1:0] pot_lvl, temp_smp, vref_smp;
   mode_type            view_mode;
   logic [TIME_W-1:0]   hold_t0;

   monitor_req_type pend_q[$];
   display_rsp_type display_q[$];
   int           queued_cnt = 0;
   int           taken_cnt = 0;
   int           errors = 0;
   int           cycle_cnt = 0;
   int           src_idle_pct = 0;
   int           snk_stall_pct = 0;
   int           stall_left = 0;
   bit           req_taken = 0;
   logic [TIME_W-1:0] wall_ms;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic reset_predictor();
      cal_lo     = TEMP_CAL_LOW_RST;
      cal_hi     = TEMP_CAL_HIGH_RST;
      vref_cal_r = VREF_CAL_RST;
      hold_r     = HOLD_MS_RST;
      chan_ctr   = '0;
      flt_sum    = '0;
      pot_lvl    = '0;
      temp_smp   = '0;
      vref_smp   = '0;
      view_mode  = MODE_POT;
      hold_t0    = '0;
   endtask

   task automatic predict_display(input monitor_req_type it);
      logic [31:0]  lvl;
      logic [31:0]  lim;
      int           den, num, val;
      bit           fault;
      mode_type     shown;
      display_rsp_type r;
      if (it.cmd == CMD_CONV) begin
         case (chan_ctr)
            2'd0: begin
               lvl = 32'(flt_sum >> FILTER_SHIFT_DEF);
               if (lvl > 4095) lvl = 4095;
               pot_lvl = lvl[SAMPLE_W-1:0];
               flt_sum = SUM_W'(flt_sum - lvl + it.sample);
            end
            2'd1: temp_smp = it.sample;
            2'd2: vref_smp = it.sample;
            default: ;
         endcase
         if (it.eos) chan_ctr = 2'd0;
         else if (chan_ctr < 2'd3) chan_ctr = chan_ctr + 2'd1;
      end else begin
         val = 0;
         fault = 1'b0;
         shown = view_mode;
         case (view_mode)
            MODE_TEMP: begin
               den = int'(cal_hi) - int'(cal_lo);
               num = (int'(temp_smp) - int'(cal_lo)) * 80;
               if (den == 0) fault = 1'b1;
               else val = num / den + 30;
            end
            MODE_VOLT: begin
               if (vref_smp == 0) fault = 1'b1;
               else val = int'((330 * vref_cal_r) / vref_smp);
            end
            default: begin
               shown = MODE_POT;
               val = int'((pot_lvl * 500) / 4096);
            end
         endcase
         r.value = val[VALUE_W-1:0];
         r.bar   = BAR_W'((pot_lvl * 9) / 4096);
         r.mode  = shown;
         r.fault = fault;
         display_q.push_back(r);
         if (it.s1) begin
            view_mode = MODE_VOLT;
            hold_t0 = it.now;
         end
         if (it.s2) begin
            view_mode = MODE_TEMP;
            hold_t0 = it.now;
         end
         lim = hold_t0 + hold_r;
         if (it.now > lim) view_mode = MODE_POT;
      end
   endtask

   // driver: next transaction offered at the falling edge
   always @(negedge clock) begin
      monitor_req_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pend_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            it = pend_q.pop_front();
            req_chan.cmd             <= it.cmd;
            req_chan.sample          <= it.sample;
            req_chan.end_of_sequence <= it.eos;
            req_chan.s1_pressed      <= it.s1;
            req_chan.s2_pressed      <= it.s2;
            req_chan.now_ms          <= it.now;
            req_chan.valid           <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: long hold-off first, otherwise random stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      monitor_req_type it;
      display_rsp_type e;
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         it.cmd    = req_chan.cmd;
         it.sample = req_chan.sample;
         it.eos    = req_chan.end_of_sequence;
         it.s1     = req_chan.s1_pressed;
         it.s2     = req_chan.s2_pressed;
         it.now    = req_chan.now_ms;
         taken_cnt++;
         predict_display(it);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (display_q.size() == 0) begin
            $error("unexpected result transaction: display_value %0d",
                   $signed(rsp_chan.display_value));
            errors++;
         end else begin
            e = display_q.pop_front();
            if (rsp_chan.display_value !== e.value) begin
               $error("display_value: expected %0d, got %0d",
                      $signed(e.value), $signed(rsp_chan.display_value));
               errors++;
            end
            if (rsp_chan.bar_level !== e.bar) begin
               $error("bar_level: expected %0d, got %0d", e.bar, rsp_chan.bar_level);
               errors++;
            end
            if (rsp_chan.shown_mode !== e.mode) begin
               $error("shown_mode: expected %0d, got %0d", e.mode, rsp_chan.shown_mode);
               errors++;
            end
            if (rsp_chan.div_fault !== e.fault) begin
               $error("div_fault: expected %0d, got %0d", e.fault, rsp_chan.div_fault);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_item(input monitor_req_type it);
      pend_q.push_back(it);
      queued_cnt++;
   endtask

   function automatic monitor_req_type rand_item(input bit cmd);
      monitor_req_type it;
      int           r;
      r = $urandom_range(0, 19);
      it.cmd = cmd;
      if (r == 0) it.sample = '0;
      else if (r == 1) it.sample = '1;
      else it.sample = SAMPLE_W'($urandom_range(0, 4095));
      it.eos = 1'($urandom_range(0, 1));
      it.s1  = 1'($urandom_range(0, 1));
      it.s2  = 1'($urandom_range(0, 1));
      it.now = $urandom();
      return it;
   endfunction

   task automatic add_conv(input int smp, input bit eos);
      monitor_req_type it;
      it = rand_item(CMD_CONV);
      it.sample = SAMPLE_W'(smp);
      it.eos = eos;
      push_item(it);
   endtask

   task automatic add_poll(input bit s1, input bit s2, input logic [TIME_W-1:0] now);
      monitor_req_type it;
      it = rand_item(CMD_POLL);
      it.s1 = s1;
      it.s2 = s2;
      it.now = now;
      push_item(it);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TEMP_CAL_LOW:  cal_lo = val[CAL_W-1:0];
         CSR_TEMP_CAL_HIGH: cal_hi = val[CAL_W-1:0];
         CSR_VREF_CAL:      vref_cal_r = val[CAL_W-1:0];
         CSR_HOLD_MS:       hold_r = val[HOLD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int lo, input int hi, input int vref, input int hold);
      csr_write(CSR_TEMP_CAL_LOW, CSR_DATA_W'(lo));
      csr_write(CSR_TEMP_CAL_HIGH, CSR_DATA_W'(hi));
      csr_write(CSR_VREF_CAL, CSR_DATA_W'(vref));
      csr_write(CSR_HOLD_MS, CSR_DATA_W'(hold));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // every queued transaction taken and every result seen, then a quiet tail
   task automatic wait_drained();
      do @(negedge clock);
      while (taken_cnt != queued_cnt || display_q.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic gen_random(input int n);
      monitor_req_type it;
      int           cnt, len, r, k;
      cnt = 0;
      while (cnt < n) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            // sequence of one to four conversions, eos on the last conversion
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
               it = rand_item(CMD_CONV);
               it.eos = (k == len - 1);
               if (k == 0 && $urandom_range(0, 3) != 0)
                  it.sample = SAMPLE_W'($urandom_range(3000, 4095));
               push_item(it);
               cnt++;
            end
         end else if (r < 85) begin
            it = rand_item(CMD_POLL);
            it.s1 = ($urandom_range(0, 99) < 30);
            it.s2 = ($urandom_range(0, 99) < 20);
            if ($urandom_range(0, 99) < 8) wall_ms = $urandom();
            else wall_ms = wall_ms + $urandom_range(0, hold_r + hold_r / 4 + 4);
            it.now = wall_ms;
            push_item(it);
            cnt++;
         end else begin
            push_item(rand_item(CMD_CONV));
            cnt++;
         end
      end
   endtask

   initial begin
      int ph, lo, hi, vref, hold;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TEMP_CAL_LOW;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_CONV;
      req_chan.sample = '0;
      req_chan.end_of_sequence = 1'b0;
      req_chan.s1_pressed = 1'b0;
      req_chan.s2_pressed = 1'b0;
      req_chan.now_ms = '0;
      rsp_chan.ready = 1'b0;
      reset_predictor();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: channel routing, zero divisors, button priority, hold expiry
      add_conv(4095, 1'b0);
      add_conv(0, 1'b0);
      add_conv(0, 1'b1);
      add_poll(1'b1, 1'b0, 100);
      add_poll(1'b0, 1'b0, 600);
      add_poll(1'b0, 1'b1, 700);
      add_poll(1'b0, 1'b0, 800);
      add_poll(1'b1, 1'b1, 900);
      add_poll(1'b0, 1'b0, 1901);
      add_poll(1'b0, 1'b0, 1902);
      add_conv(4095, 1'b0);
      add_conv(4095, 1'b0);
      add_conv(4095, 1'b0);
      add_conv(123, 1'b0);
      add_conv(4095, 1'b0);
      add_conv(0, 1'b1);
      // hold limit wraps past 2^32
      add_poll(1'b1, 1'b0, 32'hFFFF_FF00);
      add_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
      add_poll(1'b1, 1'b0, 5);
      add_poll(1'b0, 1'b0, 32'hFFFF_FFFF);
      add_poll(1'b0, 1'b1, 10);
      add_poll(1'b0, 1'b0, 20);
      wait_drained();

      for (ph = 1; ph <= NUM_PHASES; ph++) begin
         case (ph)
            1: begin lo = 0;    hi = 4095; vref = 4095; hold = 0;     end
            2: begin lo = 4095; hi = 0;    vref = 0;    hold = 65535; end
            3: begin
               lo = $urandom_range(0, 4095);
               hi = lo;
               vref = $urandom_range(0, 4095);
               hold = $urandom_range(0, 2000);
            end
            default: begin
               lo = $urandom_range(0, 4095);
               hi = $urandom_range(0, 4095);
               vref = $urandom_range(0, 4095);
               hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 3000);
            end
         endcase
         set_config(lo, hi, vref, hold);
         src_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 9 : 59) : 0;
         snk_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 9 : 59) : 0;
         wall_ms = $urandom();
         @(posedge clock);
         // receiver holds off while polls keep coming, so the block backs up
         if (ph == 4) stall_left = 400;
         gen_random(ITEMS_PER_PHASE);
         wait_drained();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
